### design/fwil_pkg.sv
// ----------------------------------------------------------------------------
// fwil_pkg
// Shared types, constants and status codes of the firmware image length parser.
// ----------------------------------------------------------------------------
package fwil_pkg;

   localparam logic [7:0]  MAGIC_BYTE     = 8'hE9;
   localparam logic [4:0]  HEADER_LAST    = 5'd23;
   localparam logic [4:0]  SEG_HEADER_LAST = 5'd7;
   localparam logic [31:0] HEADER_LEN     = 32'd24;
   localparam logic [31:0] SEG_HEADER_LEN = 32'd8;
   localparam logic [31:0] HASH_LEN       = 32'd32;
   localparam logic [31:0] CHECKSUM_PAD   = 32'd16;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] length_type;
   typedef logic [1:0]  status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_MAGIC = 2'd1;
   localparam status_type STATUS_TRUNCATED = 2'd2;

   // request to the total length stage
   typedef struct packed {
      length_type base_length;
      logic       hash_present;
   } total_req_type;

endpackage

### design/fwil_channels_if.sv
// ----------------------------------------------------------------------------
// fwil channels
// Valid/ready channels carrying image words in and length results out.
// ----------------------------------------------------------------------------
interface fwil_req_if;
   logic                 valid;
   logic                 ready;
   fwil_pkg::byte_type   image_byte;
   logic                 final_byte;

   modport source (output valid, output image_byte, output final_byte, input ready);
   modport sink   (input valid, input image_byte, input final_byte, output ready);
endinterface

interface fwil_rsp_if;
   logic                 valid;
   logic                 ready;
   fwil_pkg::length_type image_length;
   fwil_pkg::status_type status;

   modport source (output valid, output image_length, output status, input ready);
   modport sink   (input valid, input image_length, input status, output ready);
endinterface

### design/fwil_total.sv
// ----------------------------------------------------------------------------
// fwil_total
// Final image length: pad past a checksum byte to a 16-byte boundary, add hash.
// ----------------------------------------------------------------------------
module fwil_total (
   input  fwil_pkg::total_req_type total_req,
   output fwil_pkg::length_type    total_length
);
   import fwil_pkg::*;

   length_type tail_length;

   // one checksum byte, then pad to 16: clear low nibble and add 16
   assign tail_length  = total_req.hash_present ? (CHECKSUM_PAD + HASH_LEN) : CHECKSUM_PAD;
   assign total_length = {total_req.base_length[31:4], 4'b0000} + tail_length;

endmodule

### design/firmware_image_length_parser_unit.sv
// ----------------------------------------------------------------------------
// firmware_image_length_parser_unit
// Streaming parser that reports the total length of a firmware image.
// ----------------------------------------------------------------------------
// Usage:
//   req_port takes one image word per handshake: image_byte and final_byte,
//   the latter high on the last available word of an image.
//   rsp_port returns at most one result per image: image_length and status
//   (ok, bad magic byte, truncated). image_length is zero unless status is ok.
//   A word is taken every cycle while req_port is ready; it is parsed in the
//   cycle it is accepted; its result is in the output register the next cycle.
//   The rate is set by the parse counters and the length adder, which
//   complete one word per cycle.
//   When the receiver stalls, the result waits in the output register and
//   req_port stays ready as long as that register is free or is being drained
//   in the same cycle.
//   Words after a result are dropped until final_byte, then the parser rearms.
//   Reset (synchronous) returns the parser to the start of an image header and
//   empties the output register.
// ----------------------------------------------------------------------------
module firmware_image_length_parser_unit (
   input logic     clock,
   input logic     reset,
   fwil_req_if.sink   req_port,
   fwil_rsp_if.source rsp_port
);
   import fwil_pkg::*;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SEGHDR = 2'd1;
   localparam logic [1:0] PH_SKIP   = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   length_type  run_len_ff, run_len_in;
   logic [7:0]  segs_left_ff, segs_left_in;
   logic        hash_ff, hash_in;
   length_type  seg_len_ff, seg_len_in;
   length_type  skip_ff, skip_in;

   logic        rsp_valid_ff, rsp_valid_in;
   length_type  rsp_len_ff, rsp_len_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic          req_fire;
   logic          done;
   logic          emit;
   logic          rearm;
   status_type    done_status;
   length_type    seg_len_new;
   length_type    seg_run_len;
   logic [7:0]    segs_dec;
   total_req_type total_req;
   length_type    total_length;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_fire       = req_port.valid && req_port.ready;

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.image_length = rsp_len_ff;
   assign rsp_port.status       = rsp_status_ff;

   // little-endian data length from segment header bytes 4..7
   always_comb begin
      seg_len_new = seg_len_ff;
      case (pos_ff)
         5'd4: seg_len_new[7:0]   = req_port.image_byte;
         5'd5: seg_len_new[15:8]  = req_port.image_byte;
         5'd6: seg_len_new[23:16] = req_port.image_byte;
         5'd7: seg_len_new[31:24] = req_port.image_byte;
         default: seg_len_new = seg_len_ff;
      endcase
   end

   assign seg_run_len = run_len_ff + SEG_HEADER_LEN + seg_len_new;
   assign segs_dec    = segs_left_ff - 8'd1;

   always_comb begin
      if (phase_ff == PH_HEADER) begin
         total_req.base_length  = run_len_ff;
         total_req.hash_present = (req_port.image_byte != 8'd0);
      end else begin
         total_req.base_length  = seg_run_len;
         total_req.hash_present = hash_ff;
      end
   end

   fwil_total u_total (
      .total_req    (total_req),
      .total_length (total_length)
   );

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      run_len_in   = run_len_ff;
      segs_left_in = segs_left_ff;
      hash_in      = hash_ff;
      seg_len_in   = seg_len_ff;
      skip_in      = skip_ff;
      done         = 1'b0;
      done_status  = STATUS_OK;
      rearm        = 1'b0;
      emit         = 1'b0;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;

      if (req_fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == 5'd0 && req_port.image_byte != MAGIC_BYTE) begin
                  done        = 1'b1;
                  done_status = STATUS_BAD_MAGIC;
               end else begin
                  if (pos_ff == 5'd1) begin
                     segs_left_in = req_port.image_byte;
                  end
                  if (pos_ff == HEADER_LAST) begin
                     hash_in = (req_port.image_byte != 8'd0);
                     if (segs_left_ff == 8'd0) begin
                        done = 1'b1;
                     end else begin
                        phase_in   = PH_SEGHDR;
                        pos_in     = 5'd0;
                        seg_len_in = '0;
                     end
                  end else begin
                     pos_in = pos_ff + 5'd1;
                  end
               end
            end
            PH_SEGHDR: begin
               if (pos_ff == SEG_HEADER_LAST) begin
                  run_len_in   = seg_run_len;
                  segs_left_in = segs_dec;
                  pos_in       = 5'd0;
                  seg_len_in   = '0;
                  if (segs_dec == 8'd0) begin
                     done = 1'b1;
                  end else if (seg_len_new == '0) begin
                     phase_in = PH_SEGHDR;
                  end else begin
                     skip_in  = seg_len_new;
                     phase_in = PH_SKIP;
                  end
               end else begin
                  seg_len_in = seg_len_new;
                  pos_in     = pos_ff + 5'd1;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in   = PH_SEGHDR;
                  pos_in     = 5'd0;
                  seg_len_in = '0;
               end
            end
            default: begin
               rearm = req_port.final_byte;
            end
         endcase

         if (done) begin
            emit          = 1'b1;
            rsp_status_in = done_status;
            rsp_len_in    = (done_status == STATUS_OK) ? total_length : '0;
            if (req_port.final_byte) begin
               rearm = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end else if (req_port.final_byte && phase_ff != PH_DONE) begin
            // image ended before its length was known
            emit          = 1'b1;
            rsp_status_in = STATUS_TRUNCATED;
            rsp_len_in    = '0;
            rearm         = 1'b1;
         end

         if (rearm) begin
            phase_in     = PH_HEADER;
            pos_in       = 5'd0;
            run_len_in   = HEADER_LEN;
            segs_left_in = 8'd0;
            hash_in      = 1'b0;
            seg_len_in   = '0;
            skip_in      = '0;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= 5'd0;
         run_len_ff   <= HEADER_LEN;
         segs_left_ff <= 8'd0;
         hash_ff      <= 1'b0;
         seg_len_ff   <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         run_len_ff   <= run_len_in;
         segs_left_ff <= segs_left_in;
         hash_ff      <= hash_in;
         seg_len_ff   <= seg_len_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the firmware image length parser: streams whole images, cut
// images, bad magic bytes and noise through the word channel, predicts each
// length result in step with the stream and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
   import fwil_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_WORDS = 600;
   localparam int MIN_IMAGES   = 12;

   typedef enum logic [1:0] {
      IN_MAIN_HEADER,
      IN_SEG_HEADER,
      IN_SEG_DATA,
      AFTER_RESULT
   } parse_phase_type;

   typedef struct {
      byte_type   value;
      logic       last;
      bit         typed;
      length_type exp_length;
      status_type exp_status;
   } image_word_type;

   typedef struct {
      length_type image_length;
      status_type status;
   } length_result_type;

   // one directed image: cut > 0 ends it after that many words, -1 at random
   typedef struct packed {
      byte_type   magic;
      byte_type   seg_count;
      byte_type   hash_byte;
      int         data_lo;
      length_type last_len;
      int         cut;
      int         tail;
      bit         typed;
      length_type exp_length;
      status_type exp_status;
   } image_case_type;

   logic clock;
   logic reset;
   int   cycle_count;
   int   error_count;
   int   words_sent;

   image_word_type    image_words[$];
   length_result_type expected_lengths[$];

   // predicted parser state
   parse_phase_type parse_phase;
   logic [4:0]      word_index;
   length_type      total_so_far;
   logic [7:0]      segments_left;
   logic            hash_seen;
   length_type      seg_length;
   length_type      skip_left;

   fwil_req_if req_ch ();
   fwil_rsp_if rsp_ch ();

   firmware_image_length_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   image_case_type case_table [18] = '{
      '{8'h00, 8'd0, 8'h00, 0, 32'd0, 1, 0, 1'b1, 32'd0, STATUS_BAD_MAGIC},
      '{8'hFF, 8'd2, 8'h00, 0, 32'd0, 0, 3, 1'b1, 32'd0, STATUS_BAD_MAGIC},
      '{8'hE8, 8'd0, 8'h00, 0, 32'd0, 5, 0, 1'b1, 32'd0, STATUS_BAD_MAGIC},
      '{MAGIC_BYTE, 8'd0, 8'h00, 0, 32'd0, 1, 0, 1'b1, 32'd0, STATUS_TRUNCATED},
      '{MAGIC_BYTE, 8'd0, 8'h00, 0, 32'd0, 0, 0, 1'b1, 32'd32, STATUS_OK},
      '{MAGIC_BYTE, 8'd0, 8'hFF, 0, 32'd0, 0, 4, 1'b1, 32'd64, STATUS_OK},
      '{MAGIC_BYTE, 8'd0, 8'h01, 0, 32'd0, 0, 1, 1'b1, 32'd64, STATUS_OK},
      '{MAGIC_BYTE, 8'd0, 8'h00, 0, 32'd0, 23, 0, 1'b1, 32'd0, STATUS_TRUNCATED},
      '{MAGIC_BYTE, 8'd1, 8'h00, 0, 32'd0, 0, 0, 1'b0, 32'd0, STATUS_OK},
      '{MAGIC_BYTE, 8'd1, 8'h01, 0, 32'hFFFFFFFF, 0, 2, 1'b0, 32'd0, STATUS_OK},
      '{MAGIC_BYTE, 8'd1, 8'h00, 0, 32'hFFFFFFF0, 0, 0, 1'b0, 32'd0, STATUS_OK},
      '{MAGIC_BYTE, 8'd3, 8'h00, 0, 32'd5, 0, 0, 1'b0, 32'd0, STATUS_OK},
      '{MAGIC_BYTE, 8'd2, 8'h40, 10, 32'h12345678, 0, 2, 1'b0, 32'd0, STATUS_OK},
      '{MAGIC_BYTE, 8'd2, 8'h00, 10, 32'd0, 37, 0, 1'b1, 32'd0, STATUS_TRUNCATED},
      '{MAGIC_BYTE, 8'd3, 8'h00, 3, 32'd0, 39, 0, 1'b1, 32'd0, STATUS_TRUNCATED},
      '{MAGIC_BYTE, 8'd2, 8'h00, 6, 32'd0, 38, 0, 1'b1, 32'd0, STATUS_TRUNCATED},
      '{MAGIC_BYTE, 8'd1, 8'h00, 0, 32'd0, 31, 0, 1'b1, 32'd0, STATUS_TRUNCATED},
      '{MAGIC_BYTE, 8'd16, 8'h80, 0, 32'h80000000, 0, 1, 1'b0, 32'd0, STATUS_OK}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic void rearm_parser();
      parse_phase   = IN_MAIN_HEADER;
      word_index    = '0;
      total_so_far  = HEADER_LEN;
      segments_left = '0;
      hash_seen     = 1'b0;
      seg_length    = '0;
      skip_left     = '0;
   endfunction

   // checksum byte padded to 16, then the hash if present
   function automatic length_type padded_total();
      length_type t;
      t = (total_so_far | (CHECKSUM_PAD - 1)) + 1;
      if (hash_seen) t = t + HASH_LEN;
      return t;
   endfunction

   function automatic void parse_word(input byte_type value, input logic last,
         output bit produced, output length_type image_length, output status_type status);
      bit done;
      bit was_done;
      produced     = 1'b0;
      image_length = '0;
      status       = STATUS_OK;
      done         = 1'b0;
      was_done     = (parse_phase == AFTER_RESULT);
      case (parse_phase)
         IN_MAIN_HEADER: begin
            if (word_index == 0 && value != MAGIC_BYTE) begin
               done   = 1'b1;
               status = STATUS_BAD_MAGIC;
            end else begin
               if (word_index == 1) segments_left = value;
               if (word_index == HEADER_LAST) begin
                  hash_seen = (value != 0);
                  if (segments_left == 0) begin
                     done         = 1'b1;
                     image_length = padded_total();
                  end else begin
                     parse_phase = IN_SEG_HEADER;
                     word_index  = '0;
                     seg_length  = '0;
                  end
               end else begin
                  word_index = word_index + 5'd1;
               end
            end
         end
         IN_SEG_HEADER: begin
            if (word_index >= 4) seg_length[8 * (word_index - 4) +: 8] = value;
            if (word_index == SEG_HEADER_LAST) begin
               total_so_far  = total_so_far + SEG_HEADER_LEN + seg_length;
               segments_left = segments_left - 8'd1;
               word_index    = '0;
               if (segments_left == 0) begin
                  done         = 1'b1;
                  image_length = padded_total();
               end else if (seg_length != 0) begin
                  skip_left   = seg_length;
                  parse_phase = IN_SEG_DATA;
               end
               seg_length = '0;
            end else begin
               word_index = word_index + 5'd1;
            end
         end
         IN_SEG_DATA: begin
            skip_left = skip_left - 1;
            if (skip_left == 0) begin
               parse_phase = IN_SEG_HEADER;
               word_index  = '0;
               seg_length  = '0;
            end
         end
         default: ;
      endcase

      if (was_done) begin
         if (last) rearm_parser();
      end else if (done) begin
         produced = 1'b1;
         if (last) rearm_parser();
         else parse_phase = AFTER_RESULT;
      end else if (last) begin
         produced     = 1'b1;
         image_length = '0;
         status       = STATUS_TRUNCATED;
         rearm_parser();
      end
   endfunction

   task automatic push_word(input byte_type value, input logic last, input image_case_type c);
      image_words.push_back('{value, last, c.typed, c.exp_length, c.exp_status});
   endtask

   // non-last segments carry between data_lo and data_hi data words
   task automatic queue_image(input image_case_type c, input int data_hi);
      byte_type   img[$];
      length_type seg_len;
      int         cut_at;
      img.push_back(c.magic);
      img.push_back(c.seg_count);
      repeat (21) img.push_back(byte_type'($urandom_range(255)));
      img.push_back(c.hash_byte);
      for (int s = 0; s < c.seg_count; s++) begin
         if (s == c.seg_count - 1) seg_len = c.last_len;
         else seg_len = $urandom_range(data_hi, c.data_lo);
         repeat (4) img.push_back(byte_type'($urandom_range(255)));
         for (int k = 0; k < 4; k++) img.push_back(seg_len[8 * k +: 8]);
         if (s != c.seg_count - 1) repeat (seg_len) img.push_back(byte_type'($urandom_range(255)));
      end
      cut_at = c.cut;
      if (cut_at < 0) cut_at = $urandom_range(img.size() - 1, 1);
      if (cut_at > 0) begin
         while (img.size() > cut_at) void'(img.pop_back());
      end else begin
         repeat (c.tail) img.push_back(byte_type'($urandom_range(255)));
      end
      for (int i = 0; i < img.size(); i++) push_word(img[i], i == img.size() - 1, c);
   endtask

   task automatic build_stimulus();
      image_case_type c;
      int             roll;
      int             data_hi;
      int             directed_words;
      int             random_images;
      int             noise_len;
      foreach (case_table[i]) queue_image(case_table[i], case_table[i].data_lo);
      directed_words = image_words.size();
      random_images  = 0;
      while (image_words.size() < directed_words + RANDOM_WORDS || random_images < MIN_IMAGES) begin
         roll        = $urandom_range(99);
         c           = '0;
         c.magic     = MAGIC_BYTE;
         c.seg_count = byte_type'($urandom_range(3));
         if ($urandom_range(19) == 0) c.seg_count = byte_type'($urandom_range(40, 4));
         c.hash_byte = ($urandom_range(1) == 0) ? 8'h00 : byte_type'($urandom_range(255, 1));
         c.last_len  = ($urandom_range(1) == 0) ? length_type'($urandom)
                                               : length_type'($urandom_range(300));
         c.tail      = $urandom_range(3);
         data_hi     = $urandom_range(8);
         if (roll < 70) begin
            queue_image(c, data_hi);
         end else if (roll < 82) begin
            c.cut = -1;
            queue_image(c, data_hi);
         end else if (roll < 92) begin
            c.magic = byte_type'($urandom_range(254));
            if (c.magic >= MAGIC_BYTE) c.magic = c.magic + 8'd1;
            if ($urandom_range(3) == 0) c.cut = 1;
            queue_image(c, data_hi);
         end else begin
            // noise run, sometimes opening like a real header
            noise_len = $urandom_range(8, 1);
            for (int i = 0; i < noise_len; i++) begin
               push_word((i == 0 && $urandom_range(1) == 0) ? MAGIC_BYTE
                                                            : byte_type'($urandom_range(255)),
                         (i == noise_len - 1) || ($urandom_range(3) == 0), c);
            end
         end
         random_images++;
      end
   endtask

   function automatic int sender_idle_pct();
      if (words_sent * 3 < image_words.size()) return 28;
      if (words_sent * 3 < image_words.size() * 2) return 57;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (words_sent * 3 < image_words.size()) return 57;
      if (words_sent * 3 < image_words.size() * 2) return 28;
      return 0;
   endfunction

   always @(posedge clock) begin : drive_words
      int         next_index;
      bit         produced;
      length_type predicted_length;
      status_type predicted_status;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         next_index = words_sent;
         if (req_ch.valid && req_ch.ready) begin
            parse_word(image_words[next_index].value, image_words[next_index].last,
                       produced, predicted_length, predicted_status);
            if (produced) begin
               if (image_words[next_index].typed) begin
                  expected_lengths.push_back('{image_words[next_index].exp_length,
                                               image_words[next_index].exp_status});
               end else begin
                  expected_lengths.push_back('{predicted_length, predicted_status});
               end
            end
            next_index++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (next_index < image_words.size() && $urandom_range(99) >= sender_idle_pct()) begin
               req_ch.valid      <= 1'b1;
               req_ch.image_byte <= image_words[next_index].value;
               req_ch.final_byte <= image_words[next_index].last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         words_sent <= next_index;
      end
   end

   always @(posedge clock) begin : check_lengths
      length_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_lengths.size() == 0) begin
               $display("%0t: unexpected result, image_length %0d status %0d",
                        $time, rsp_ch.image_length, rsp_ch.status);
               error_count++;
            end else begin
               want = expected_lengths.pop_front();
               if (rsp_ch.image_length !== want.image_length) begin
                  $display("%0t: image_length expected %0d, got %0d",
                           $time, want.image_length, rsp_ch.image_length);
                  error_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_ch.status);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.image_byte = '0;
      req_ch.final_byte = 1'b0;
      rsp_ch.ready      = 1'b0;
      cycle_count       = 0;
      error_count       = 0;
      words_sent        = 0;
      rearm_parser();
      build_stimulus();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while ((words_sent < image_words.size() || expected_lengths.size() != 0)
             && cycle_count < CYCLE_LIMIT) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
      end else begin
         // let any stray result show up before the verdict
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (error_count == 0) begin
            $display("SUCCESS");
         end else begin
            $display("FAILURE");
         end
      end
      $finish;
   end

endmodule

### files.f
design/fwil_pkg.sv
design/fwil_channels_if.sv
design/fwil_total.sv
design/firmware_image_length_parser_unit.sv
test/tb.sv
